// ===== rtl/integrating_debouncer_hysteresis_macros.svh =====
// Assertion macros used by the integrating debouncer top level.
`ifndef INTEGRATING_DEBOUNCER_HYSTERESIS_MACROS_SVH
`define INTEGRATING_DEBOUNCER_HYSTERESIS_MACROS_SVH

// Same-cycle implication, checked on aclk and idle while aresetn is low.
`define IDH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("integrating debouncer: same-cycle check failed");

// Next-cycle implication, checked on aclk and idle while aresetn is low.
`define IDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("integrating debouncer: next-cycle check failed");

`endif

// ===== rtl/idh_pkg.sv =====
// Package with widths, reset values and shared types of the integrating debouncer.
`default_nettype none

package idh_pkg;

    localparam int LIMIT_W               = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd8;
    localparam int COUNTER_WIDTH_DEFAULT = 8;

    // Control handed from the handshake logic to the debounce core.
    typedef struct packed {
        logic step;
        logic pin_level;
    } core_in_t;

endpackage

`default_nettype wire

// ===== rtl/idh_core.sv =====
// Debounce core: integrator, hold-off counter and qualified state with hysteresis.
`default_nettype none

module idh_core #(
    parameter int COUNTER_WIDTH = idh_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire idh_pkg::core_in_t            core_in,
    input  wire logic [idh_pkg::LIMIT_W-1:0]  integrate_limit,
    output logic                              state_next
);
    import idh_pkg::*;

    localparam int LIM_W = (COUNTER_WIDTH > LIMIT_W) ? COUNTER_WIDTH : LIMIT_W;

    logic [COUNTER_WIDTH-1:0] integrator_reg, integrator_next;
    logic [COUNTER_WIDTH-1:0] holdoff_reg, holdoff_next;
    logic                     state_reg;
    logic [LIM_W-1:0]         lim_wide;
    logic [LIM_W-1:0]         cnt_max_wide;
    logic [COUNTER_WIDTH-1:0] lim;
    logic [COUNTER_WIDTH-1:0] upper;
    logic [COUNTER_WIDTH-1:0] lower;
    logic                     target;

    // The limit in effect saturates at the largest counter value.
    assign lim_wide     = LIM_W'(integrate_limit);
    assign cnt_max_wide = LIM_W'({COUNTER_WIDTH{1'b1}});
    assign lim = (lim_wide > cnt_max_wide) ? cnt_max_wide[COUNTER_WIDTH-1:0]
                                           : lim_wide[COUNTER_WIDTH-1:0];
    assign upper = (lim >> 1) + (lim >> 2);
    assign lower = lim >> 2;

    always_comb begin
        integrator_next = integrator_reg;
        if (core_in.pin_level && (integrator_reg < lim)) begin
            integrator_next = integrator_reg + COUNTER_WIDTH'(1);
        end else if (!core_in.pin_level && (integrator_reg != '0)) begin
            integrator_next = integrator_reg - COUNTER_WIDTH'(1);
        end

        target = state_reg;
        if (integrator_next > upper) begin
            target = 1'b1;
        end else if (integrator_next < lower) begin
            target = 1'b0;
        end

        state_next   = state_reg;
        holdoff_next = holdoff_reg;
        if (holdoff_reg >= lim) begin
            if (target != state_reg) begin
                state_next   = target;
                holdoff_next = '0;
            end
        end else begin
            holdoff_next = holdoff_reg + COUNTER_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integrator_reg <= '0;
            holdoff_reg    <= '0;
            state_reg      <= 1'b0;
        end else if (core_in.step) begin
            integrator_reg <= integrator_next;
            holdoff_reg    <= holdoff_next;
            state_reg      <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/integrating_debouncer_hysteresis.sv =====
// Top level of the integrating debouncer with hysteresis for one limit-switch pin.
// Each input word is one sample of the pin. A saturating integrator climbs toward
// integrate_limit while the pin is high and falls toward zero while it is low; once
// a hold-off of integrate_limit samples has passed since the last change, the
// debounced state sets when the integrator exceeds (limit>>1)+(limit>>2) and clears
// when it drops below limit>>2. Every sample yields exactly one result word holding
// the debounced state after that sample. The block takes one word per clock when the
// output is drained: the whole update is a single pass of compare and increment
// logic on the state registers, and the result is loaded into an output register
// at the edge that accepts the input word. The input stays ready while that
// register is empty or is being drained in the same cycle, so a steady stream
// runs at one word per cycle. integrate_limit resets to 8 and is written through
// cfg_wr_en/cfg_wr_data; write it only while no sample is in flight. A limit larger
// than the counters can hold is clipped to the counter maximum.
`default_nettype none

module integrating_debouncer_hysteresis #(
    parameter int COUNTER_WIDTH = idh_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [idh_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_pin_level,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_debounced_state
);
    import idh_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic               m_valid_reg;
    logic               m_state_reg;
    logic               s_accept;
    logic               state_next;
    core_in_t           core_in;

    // A word is taken whenever the output register is free or emptying now.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign core_in.step      = s_accept;
    assign core_in.pin_level = s_pin_level;

    idh_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .core_in         (core_in),
        .integrate_limit (limit_reg),
        .state_next      (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Output register: loaded on every accepted sample, cleared when drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_state_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
            m_state_reg <= state_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_debounced_state = m_state_reg;

`include "integrating_debouncer_hysteresis_macros.svh"

    // An accepted sample always produces a result word in the next cycle.
`IDH_ASSERT_NEXT(a_accept_gives_result, s_accept, m_valid_reg)
    // The reported state moves only when a new sample has been taken.
`IDH_ASSERT_NEXT(a_state_moves_on_accept, !s_accept, $stable(m_state_reg))
    // An empty output register never blocks the input.
`IDH_ASSERT_NOW(a_ready_when_empty, !m_valid_reg, s_ready)

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the integrating debouncer with hysteresis.
module testbench;

    import idh_pkg::*;

    localparam int          CW          = COUNTER_WIDTH_DEFAULT;
    localparam int unsigned CNT_MAX     = (1 << CW) - 1;
    localparam int          IDLE_PCT    = 31;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          N_ROWS      = 26;
    localparam int          N_PHASES    = 14;
    localparam int          MAX_REPORTS = 10;

    // A directed row either offers one pin sample or rewrites the limit.
    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [7:0]   value;        // pin level in bit 0, or the new limit
        logic         known;        // a hand-written expectation exists
        logic         known_state;
    } row_t;

    typedef struct {
        logic state;
        logic known;
        logic known_state;
    } pending_t;

    // Directed words, starting from the reset limit of 8. Ten high samples
    // saturate the integrator and set the state once the hold-off has run
    // out; a short low burst then cannot clear it during the new hold-off.
    // With a zero limit the integrator sits above the ceiling, so a high
    // sample leaves it alone and the state is set because it is nonzero,
    // and the state is never cleared by the threshold test even when the
    // integrator has drained to zero. Full-scale and unit limits follow.
    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_SAMPLE, 8'd1,   1'b1, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_CONFIG, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b1, 1'b1},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b1, 1'b1},
        '{ROW_CONFIG, 8'd255, 1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd0,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0},
        '{ROW_CONFIG, 8'd1,   1'b0, 1'b0},
        '{ROW_SAMPLE, 8'd1,   1'b0, 1'b0}
    };

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               cfg_wr_en         = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data       = '0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic               s_pin_level       = 1'b0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic               m_debounced_state;

    // Hand-written expectation that travels with the word being offered.
    logic drive_known       = 1'b0;
    logic drive_known_state = 1'b0;

    // Receiver control: no_idle removes random back-pressure, hold_request
    // asks the receiver for one long stall.
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;
    logic hold_served  = 1'b0;
    int   hold_left    = 0;

    // Predicted debouncer state and the limit in force.
    logic [LIMIT_W-1:0] limit_q;
    logic [CW-1:0]      integ_q;
    logic [CW-1:0]      holdoff_q;
    logic               state_q;

    pending_t expected_states [$];

    int sent_count     = 0;
    int done_count     = 0;
    int asserted_count = 0;
    int limit_writes   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    integrating_debouncer_hysteresis dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pin_level       (s_pin_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_debounced_state (m_debounced_state)
    );

    always #10 aclk = ~aclk;

    // One debouncer update for one pin sample; returns the state after it.
    function automatic logic debounce_sample(input logic pin);
        int unsigned lim;
        int unsigned upper;
        int unsigned lower;
        logic        next_state;
        lim = (limit_q > CNT_MAX) ? CNT_MAX : limit_q;
        // The integrator saturates at the limit but, if the limit was
        // lowered beneath it, only a low sample moves it.
        if (pin && integ_q < lim) begin
            integ_q = integ_q + CW'(1);
        end else if (!pin && integ_q > 0) begin
            integ_q = integ_q - CW'(1);
        end
        if (holdoff_q >= lim) begin
            upper      = (lim >> 1) + (lim >> 2);
            lower      = lim >> 2;
            next_state = state_q;
            if (integ_q > upper) begin
                next_state = 1'b1;
            end else if (integ_q < lower) begin
                next_state = 1'b0;
            end
            if (next_state != state_q) begin
                state_q   = next_state;
                holdoff_q = '0;
            end
        end else begin
            holdoff_q = holdoff_q + CW'(1);
        end
        return state_q;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Everything is sampled in the active region of the rising edge, so it
    // sees the values from before the edge, as the block does. A word taken
    // in is predicted first and a word handed out is checked after it, so
    // the order holds whatever the block's latency is.
    always @(posedge aclk) begin : scoreboard
        pending_t head;
        if (!aresetn) begin
            limit_q   = LIMIT_RESET;
            integ_q   = '0;
            holdoff_q = '0;
            state_q   = 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_q = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_states.push_back('{debounce_sample(s_pin_level),
                                           drive_known, drive_known_state});
            end
            if (m_valid && m_ready) begin
                if (expected_states.size() == 0) begin
                    note_mismatch($sformatf("result word %b with no sample pending",
                                            m_debounced_state));
                end else begin
                    head = expected_states.pop_front();
                    done_count++;
                    if (m_debounced_state) begin
                        asserted_count++;
                    end
                    if (m_debounced_state !== head.state) begin
                        note_mismatch($sformatf("result %0d debounced_state expected %b got %b",
                                                done_count, head.state, m_debounced_state));
                    end
                    if (head.known && m_debounced_state !== head.known_state) begin
                        note_mismatch($sformatf("result %0d debounced_state hand value %b got %b",
                                                done_count, head.known_state,
                                                m_debounced_state));
                    end
                end
            end
        end
    end

    // Receiver: random back-pressure, one long stall on request, and none
    // at all while no_idle is set.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_request && !hold_served) begin
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= 1'b1;
            m_ready     <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d of %0d results in",
                     cycle_count, done_count, sent_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Offers one word and returns at the edge that takes it. Valid is left
    // high so a back-to-back word keeps it up without a glitch; a gap drops
    // it first.
    task automatic send_word(input logic pin, input logic known, input logic known_state);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        s_valid           <= 1'b1;
        s_pin_level       <= pin;
        drive_known       <= known;
        drive_known_state <= known_state;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Stops offering and waits until every word sent has produced its result.
    task automatic drain();
        s_valid <= 1'b0;
        while (done_count != sent_count) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_writes++;
    endtask

    // Switch-like stimulus: runs of one level, of random length from 1 to
    // 2*lim+6 samples, with occasional contact bounce inside a run. About one
    // burst in ten is plain random noise.
    task automatic play_switch(input int count, input int unsigned lim);
        int   played;
        int   run;
        logic level;
        logic pin;
        played = 0;
        level  = 1'($urandom_range(0, 1));
        while (played < count) begin
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(1, 8);
                for (int k = 0; k < run && played < count; k++) begin
                    send_word(1'($urandom_range(0, 1)), 1'b0, 1'b0);
                    played++;
                end
            end else begin
                level = ~level;
                run   = $urandom_range(1, 2 * lim + 6);
                for (int k = 0; k < run && played < count; k++) begin
                    pin = level;
                    if ($urandom_range(0, 15) == 0) begin
                        pin = ~level;
                    end
                    send_word(pin, 1'b0, 1'b0);
                    played++;
                end
            end
        end
    endtask

    initial begin
        int unsigned lim;
        int          count;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_CONFIG) begin
                drain();
                write_limit(DIRECTED_ROWS[r].value);
            end else begin
                send_word(DIRECTED_ROWS[r].value[0], DIRECTED_ROWS[r].known,
                          DIRECTED_ROWS[r].known_state);
            end
        end

        // Random phases. The first runs at full scale with no idling on
        // either side; the second starts with the long receiver stall while
        // words keep coming, so the block fills and holds its input off.
        // Every phase change drains the block before the limit is rewritten.
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            if (p == 0) begin
                lim   = 255;
                count = 520;
            end else if (p == 1) begin
                lim   = 0;
                count = 50;
            end else if (p == 2) begin
                lim   = 1;
                count = 50;
            end else begin
                lim   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(2, 16);
                count = 50;
            end
            no_idle <= (p == 0);
            if (p == 1) begin
                hold_request <= 1'b1;
            end
            write_limit(lim[LIMIT_W-1:0]);
            play_switch(count, lim);
        end

        drain();
        repeat (4) @(posedge aclk);
        if (expected_states.size() != 0) begin
            note_mismatch($sformatf("%0d expected results never arrived",
                                    expected_states.size()));
        end
        $display("covered %0d pin samples under %0d limit writes, zero and full scale included",
                 sent_count, limit_writes);
        $display("%0d results checked, %0d of them asserted, %0d mismatches",
                 done_count, asserted_count, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
